>>> design/dltq_pkg.sv
// shared types, constants and helpers of the delta-list timer queue
// no dependencies; used by dltq_ram and delta_list_timer_queue
`default_nettype none
package dltq_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IW          = $clog2(SLOTS);
  localparam int PW          = $clog2(SLOTS + 1);
  localparam int CW          = $clog2(MAX_RESULTS + 1);

  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  localparam logic [2:0] FN_START    = 3'd0;
  localparam logic [2:0] FN_STOP_ONE = 3'd1;
  localparam logic [2:0] FN_STOP_ALL = 3'd2;
  localparam logic [2:0] FN_QUERY    = 3'd3;
  localparam logic [2:0] FN_TICK     = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_EXP  = 2'd3;

  typedef logic [IW-1:0] idx_t;
  typedef logic [PW-1:0] ptr_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] event_code;
    logic [15:0] queue;
    logic [30:0] remaining;
    ptr_t        link;
  } entry_t;

  function automatic logic [30:0] sat_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? 31'h7fffffff : s[30:0];
  endfunction

endpackage
`default_nettype wire

>>> design/delta_list_timer_queue.sv
// delta-list timer queue: pool of SLOTS timers linked in expiry order
// in_* carries one command transaction (start, stop one, stop owner, query, tick),
// out_* returns its results; a tick returns one result per expired timer (up to 16) or one if none expired,
// every other command exactly one; out_last marks the final result of a command.
// cfg_* writes max_elapsed, the most time one tick may apply; write it only while idle.
// One command is in work at a time; in_ready is high only when the sequencer is idle.
// Each list step reads a slot from the slot memory (registered read)
// and evaluates it next cycle; unlinking adds a read and a write of the
// follower for merging the remainder into it.
// Query and stop walk the list once; start walks it twice (cancel, then insert).
// Tick: removes expired timers from the head, then lowers the new head's remainder.
// The result register lets the next result be computed while one waits; when the
// receiver stalls, the sequencer holds until the result register frees up.
// Synchronous reset empties the list, frees all slots and sets max_elapsed to
// 1000000; the slot memory needs no clearing.
// depends on dltq_pkg and dltq_ram
`default_nettype none
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [15:0] in_owner,
  input  wire logic [15:0] in_event_req,
  input  wire logic [30:0] in_delay,
  input  wire logic [15:0] in_queue_id,
  input  wire logic [30:0] in_elapsed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [15:0]      out_exp_owner,
  output logic [15:0]      out_exp_event,
  output logic [15:0]      out_exp_queue,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRD  = 4'd1;
  localparam logic [3:0] S_WEV  = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MWR  = 4'd4;
  localparam logic [3:0] S_FREE = 4'd5;
  localparam logic [3:0] S_INST = 4'd6;
  localparam logic [3:0] S_INSP = 4'd7;
  localparam logic [3:0] S_INSC = 4'd8;
  localparam logic [3:0] S_TRD  = 4'd9;
  localparam logic [3:0] S_TEV  = 4'd10;
  localparam logic [3:0] S_TADJ = 4'd11;
  localparam logic [3:0] S_TFIN = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // control
  logic [3:0]       state_r, state_nxt;
  ptr_t             head_r, head_nxt;
  logic [SLOTS-1:0] free_r, free_nxt;
  logic [30:0]      max_r;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [2:0]  func_r, func_nxt;
  logic [15:0] own_r, own_nxt;
  logic [15:0] ev_r, ev_nxt;
  logic [15:0] q_r, q_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [30:0] carry_r, carry_nxt;
  logic        ins_r, ins_nxt;
  ptr_t        cur_r, cur_nxt;
  ptr_t        prv_r, prv_nxt;
  entry_t      prv_e_r, prv_e_nxt;
  entry_t      cur_e_r, cur_e_nxt;
  entry_t      pend_e_r, pend_e_nxt;
  idx_t        tslot_r, tslot_nxt;
  logic        found_r, found_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        ofound_r, ofound_nxt;
  logic [15:0] oown_r, oown_nxt;
  logic [15:0] oev_r, oev_nxt;
  logic [15:0] oq_r, oq_nxt;
  logic        olast_r, olast_nxt;

  // memory port
  logic   we, re;
  idx_t   waddr, raddr;
  entry_t wdata, rd;

  dltq_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd)
  );

  logic out_free;
  logic fr_hit;
  idx_t fr_idx;
  logic hit_q, hit_one, hit_all, hit;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    fr_hit = 1'b0;
    fr_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        fr_hit = 1'b1;
        fr_idx = IW'(i);
      end
    end
  end

  assign hit_q   = (rd.owner == own_r) && ((ev_r == 16'd0) || (rd.event_code == ev_r));
  assign hit_one = (rd.owner == own_r) && (rd.event_code == ev_r);
  assign hit_all = (rd.owner == own_r);
  assign hit     = (func_r == FN_QUERY) ? hit_q :
                   (func_r == FN_STOP_ALL) ? hit_all : hit_one;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    func_nxt      = func_r;
    own_nxt       = own_r;
    ev_nxt        = ev_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    carry_nxt     = carry_r;
    ins_nxt       = ins_r;
    cur_nxt       = cur_r;
    prv_nxt       = prv_r;
    prv_e_nxt     = prv_e_r;
    cur_e_nxt     = cur_e_r;
    pend_e_nxt    = pend_e_r;
    tslot_nxt     = tslot_r;
    found_nxt     = found_r;
    st_nxt        = st_r;
    ost_nxt       = ost_r;
    ofound_nxt    = ofound_r;
    oown_nxt      = oown_r;
    oev_nxt       = oev_r;
    oq_nxt        = oq_r;
    olast_nxt     = olast_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = rd;
    re            = 1'b0;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          own_nxt   = in_owner;
          ev_nxt    = in_event_req;
          q_nxt     = in_queue_id;
          found_nxt = 1'b0;
          st_nxt    = ST_DONE;
          ins_nxt   = 1'b0;
          cur_nxt   = head_r;
          prv_nxt   = NIL;
          rem_nxt   = in_delay;
          priority if (in_func == FN_START && in_owner == 16'd0) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_DONE;
          end else if (in_func == FN_START || in_func == FN_STOP_ONE ||
                       in_func == FN_STOP_ALL || in_func == FN_QUERY) begin
            state_nxt = S_WRD;
          end else if (in_func == FN_TICK) begin
            rem_nxt   = (in_elapsed > max_r) ? max_r : in_elapsed;
            cnt_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_TRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_WRD: begin
        if (cur_r == NIL) begin
          if (func_r == FN_START) begin
            state_nxt = ins_r ? S_INST : S_FREE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          re        = 1'b1;
          raddr     = cur_r[IW-1:0];
          state_nxt = S_WEV;
        end
      end

      S_WEV: begin
        if (ins_r) begin
          if (rem_r < rd.remaining) begin
            cur_e_nxt = rd;
            state_nxt = S_INST;
          end else begin
            rem_nxt   = rem_r - rd.remaining;
            prv_nxt   = cur_r;
            prv_e_nxt = rd;
            cur_nxt   = rd.link;
            state_nxt = S_WRD;
          end
        end else if (hit && func_r == FN_QUERY) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (hit) begin
          // unlink and hand the remainder on to the follower
          found_nxt                 = 1'b1;
          free_nxt[cur_r[IW-1:0]]   = 1'b1;
          carry_nxt                 = rd.remaining;
          cur_nxt                   = rd.link;
          if (prv_r == NIL) begin
            head_nxt = rd.link;
          end else begin
            we             = 1'b1;
            waddr          = prv_r[IW-1:0];
            wdata          = prv_e_r;
            wdata.link     = rd.link;
            prv_e_nxt.link = rd.link;
          end
          state_nxt = S_MRD;
        end else begin
          prv_nxt   = cur_r;
          prv_e_nxt = rd;
          cur_nxt   = rd.link;
          state_nxt = S_WRD;
        end
      end

      S_MRD: begin
        if (cur_r == NIL) begin
          priority if (func_r == FN_STOP_ALL) state_nxt = S_WRD;
          else if (func_r == FN_START)        state_nxt = S_FREE;
          else                                state_nxt = S_DONE;
        end else begin
          re        = 1'b1;
          raddr     = cur_r[IW-1:0];
          state_nxt = S_MWR;
        end
      end

      S_MWR: begin
        we              = 1'b1;
        waddr           = cur_r[IW-1:0];
        wdata           = rd;
        wdata.remaining = sat_add(rd.remaining, carry_r);
        priority if (func_r == FN_STOP_ALL) state_nxt = S_WRD;
        else if (func_r == FN_START)        state_nxt = S_FREE;
        else                                state_nxt = S_DONE;
      end

      S_FREE: begin
        if (!fr_hit) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          tslot_nxt = fr_idx;
          ins_nxt   = 1'b1;
          cur_nxt   = head_r;
          prv_nxt   = NIL;
          state_nxt = S_WRD;
        end
      end

      S_INST: begin
        we                = 1'b1;
        waddr             = tslot_r;
        wdata.owner       = own_r;
        wdata.event_code  = ev_r;
        wdata.queue       = q_r;
        wdata.remaining   = rem_r;
        wdata.link        = cur_r;
        free_nxt[tslot_r] = 1'b0;
        state_nxt         = S_INSP;
      end

      S_INSP: begin
        if (prv_r == NIL) begin
          head_nxt = {1'b0, tslot_r};
        end else begin
          we         = 1'b1;
          waddr      = prv_r[IW-1:0];
          wdata      = prv_e_r;
          wdata.link = {1'b0, tslot_r};
        end
        state_nxt = S_INSC;
      end

      S_INSC: begin
        if (cur_r != NIL) begin
          we              = 1'b1;
          waddr           = cur_r[IW-1:0];
          wdata           = cur_e_r;
          wdata.remaining = cur_e_r.remaining - rem_r;
        end
        state_nxt = S_DONE;
      end

      S_TRD: begin
        if (head_r == NIL) begin
          state_nxt = S_TFIN;
        end else begin
          re        = 1'b1;
          raddr     = head_r[IW-1:0];
          state_nxt = (cnt_r == CW'(MAX_RESULTS)) ? S_TADJ : S_TEV;
        end
      end

      S_TEV: begin
        if (rd.remaining <= rem_r) begin
          // the previous expiry goes out once the result register is free; it is known not to be the last
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt = 1'b1;
              ost_nxt       = ST_EXP;
              ofound_nxt    = 1'b0;
              oown_nxt      = pend_e_r.owner;
              oev_nxt       = pend_e_r.event_code;
              oq_nxt        = pend_e_r.queue;
              olast_nxt     = 1'b0;
            end
            pend_nxt                 = 1'b1;
            pend_e_nxt               = rd;
            cnt_nxt                  = cnt_r + CW'(1);
            rem_nxt                  = rem_r - rd.remaining;
            head_nxt                 = rd.link;
            free_nxt[head_r[IW-1:0]] = 1'b1;
            state_nxt                = S_TRD;
          end
        end else begin
          state_nxt = S_TADJ;
        end
      end

      S_TADJ: begin
        we              = 1'b1;
        waddr           = head_r[IW-1:0];
        wdata           = rd;
        wdata.remaining = (rd.remaining > rem_r) ? rd.remaining - rem_r : 31'd0;
        state_nxt       = S_TFIN;
      end

      S_TFIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          olast_nxt     = 1'b1;
          ofound_nxt    = 1'b0;
          if (pend_r) begin
            ost_nxt  = ST_EXP;
            oown_nxt = pend_e_r.owner;
            oev_nxt  = pend_e_r.event_code;
            oq_nxt   = pend_e_r.queue;
          end else begin
            ost_nxt  = ST_DONE;
            oown_nxt = 16'd0;
            oev_nxt  = 16'd0;
            oq_nxt   = 16'd0;
          end
          pend_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = st_r;
          ofound_nxt    = found_r;
          oown_nxt      = 16'd0;
          oev_nxt       = 16'd0;
          oq_nxt        = 16'd0;
          olast_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      free_r      <= '1;
      max_r       <= 31'd1000000;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    own_r    <= own_nxt;
    ev_r     <= ev_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    carry_r  <= carry_nxt;
    ins_r    <= ins_nxt;
    cur_r    <= cur_nxt;
    prv_r    <= prv_nxt;
    prv_e_r  <= prv_e_nxt;
    cur_e_r  <= cur_e_nxt;
    pend_e_r <= pend_e_nxt;
    tslot_r  <= tslot_nxt;
    found_r  <= found_nxt;
    st_r     <= st_nxt;
    ost_r    <= ost_nxt;
    ofound_r <= ofound_nxt;
    oown_r   <= oown_nxt;
    oev_r    <= oev_nxt;
    oq_r     <= oq_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = ost_r;
  assign out_found     = ofound_r;
  assign out_exp_owner = oown_r;
  assign out_exp_event = oev_r;
  assign out_exp_queue = oq_r;
  assign out_last      = olast_r;

  // the list head is never a free slot
  a_head_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != NIL) |-> !free_r[head_r[IW-1:0]])
    else $error("list head points at a free slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RESULTS))
    else $error("expiry count beyond limit");

  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_TRD || state_r == S_TEV || state_r == S_TADJ ||
                state_r == S_TFIN))
    else $error("pending expiry outside a tick");

  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TFIN || state_r == S_DONE) && out_free) |=> (out_valid && out_last))
    else $error("final result of a command not presented");

endmodule
`default_nettype wire

>>> design/dltq_ram.sv
// slot memory of the timer queue: one write port, one registered read port
// depends on dltq_pkg for the entry layout
`default_nettype none
module dltq_ram
  import dltq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   we,
  input  wire idx_t   waddr,
  input  wire entry_t wdata,
  input  wire logic   re,
  input  wire idx_t   raddr,
  output entry_t      rdata
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the delta-list timer queue
// depends on dltq_pkg and delta_list_timer_queue; holds its own timer-list model
`default_nettype none

module testbench
  import dltq_pkg::*;
();

  class timer_scoreboard;
    typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [15:0] owner;
      logic [15:0] evt;
      logic [15:0] queue;
      logic        last;
    } notice_t;

    logic [15:0] own_q[SLOTS];
    logic [15:0] ev_q[SLOTS];
    logic [15:0] que_q[SLOTS];
    logic [30:0] rem_q[SLOTS];
    int          nxt[SLOTS];
    bit          free_q[SLOTS];
    int          head;
    logic [30:0] max_el;
    notice_t     pending[$];
    int          errors;

    function new();
      max_el = 31'd1000000;
      head = SLOTS;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) free_q[i] = 1;
    endfunction

    function logic [30:0] add_sat(logic [30:0] a, logic [30:0] b);
      logic [31:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[31] ? 31'h7fffffff : s[30:0];
    endfunction

    function void drop(int p, int n);
      int x;
      x = nxt[n];
      if (p == SLOTS) head = x; else nxt[p] = x;
      if (x != SLOTS) rem_q[x] = add_sat(rem_q[x], rem_q[n]);
      free_q[n] = 1;
    endfunction

    function bit cancel_one(logic [15:0] o, logic [15:0] e);
      int p, c;
      p = SLOTS;
      c = head;
      while (c != SLOTS) begin
        if (own_q[c] == o && ev_q[c] == e) begin
          drop(p, c);
          return 1;
        end
        p = c;
        c = nxt[c];
      end
      return 0;
    endfunction

    function bit cancel_owner(logic [15:0] o);
      int p, c, x;
      bit any;
      any = 0;
      p = SLOTS;
      c = head;
      while (c != SLOTS) begin
        x = nxt[c];
        if (own_q[c] == o) begin
          drop(p, c);
          any = 1;
        end else p = c;
        c = x;
      end
      return any;
    endfunction

    function void push(logic [1:0] st, logic f, logic [15:0] o, logic [15:0] e,
                       logic [15:0] q, logic l);
      notice_t r;
      r.status = st; r.found = f; r.owner = o; r.evt = e; r.queue = q; r.last = l;
      pending.push_back(r);
    endfunction

    // note an accepted command transaction and queue what it must produce
    function void note_command(logic [2:0] fn, logic [15:0] o, logic [15:0] e,
                               logic [30:0] dly, logic [15:0] q, logic [30:0] el);
      logic [1:0] st;
      logic f;
      logic [30:0] r, d;
      int t, p, c, n;
      st = ST_DONE;
      f = 0;
      case (fn)
        FN_START: begin
          if (o == 0) st = ST_ZERO;
          else begin
            f = cancel_one(o, e);
            t = SLOTS;
            for (int i = SLOTS - 1; i >= 0; i--) if (free_q[i]) t = i;
            if (t == SLOTS) st = ST_FULL;
            else begin
              free_q[t] = 0;
              own_q[t] = o; ev_q[t] = e; que_q[t] = q;
              r = dly;
              p = SLOTS;
              c = head;
              while (c != SLOTS && r >= rem_q[c]) begin
                r -= rem_q[c];
                p = c;
                c = nxt[c];
              end
              rem_q[t] = r;
              nxt[t] = c;
              if (p == SLOTS) head = t; else nxt[p] = t;
              if (c != SLOTS) rem_q[c] -= r;
            end
          end
        end
        FN_STOP_ONE: f = cancel_one(o, e);
        FN_STOP_ALL: f = cancel_owner(o);
        FN_QUERY: begin
          for (c = head; c != SLOTS; c = nxt[c])
            if (own_q[c] == o && (e == 0 || ev_q[c] == e)) f = 1;
        end
        FN_TICK: begin
          d = (el > max_el) ? max_el : el;
          n = 0;
          while (head != SLOTS && n < MAX_RESULTS && rem_q[head] <= d) begin
            t = head;
            d -= rem_q[t];
            head = nxt[t];
            free_q[t] = 1;
            push(ST_EXP, 0, own_q[t], ev_q[t], que_q[t], 0);
            n++;
          end
          if (head != SLOTS) rem_q[head] = (rem_q[head] > d) ? rem_q[head] - d : 31'd0;
          if (n > 0) begin
            pending[$].last = 1;
            return;
          end
        end
        default: ;
      endcase
      push(st, f, 0, 0, 0, 1);
    endfunction

    function void check_notice(notice_t act);
      notice_t x;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (act.status !== x.status) begin
        $error("status: expected %0d actual %0d", x.status, act.status); errors++;
      end
      if (act.found !== x.found) begin
        $error("found: expected %0d actual %0d", x.found, act.found); errors++;
      end
      if (act.owner !== x.owner) begin
        $error("exp_owner: expected %0h actual %0h", x.owner, act.owner); errors++;
      end
      if (act.evt !== x.evt) begin
        $error("exp_event: expected %0h actual %0h", x.evt, act.evt); errors++;
      end
      if (act.queue !== x.queue) begin
        $error("exp_queue: expected %0h actual %0h", x.queue, act.queue); errors++;
      end
      if (act.last !== x.last) begin
        $error("last: expected %0d actual %0d", x.last, act.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_func = 0;
  logic [15:0] in_owner = 0;
  logic [15:0] in_event_req = 0;
  logic [30:0] in_delay = 0;
  logic [15:0] in_queue_id = 0;
  logic [30:0] in_elapsed = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [15:0] out_exp_owner;
  logic [15:0] out_exp_event;
  logic [15:0] out_exp_queue;
  logic        out_last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [30:0] cfg_data = 0;

  timer_scoreboard timers = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  bit busy = 0;

  always #4 clk = ~clk;

  delta_list_timer_queue u_top (.*);

  // result side: random stall, check every accepted transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      timers.check_notice({out_status, out_found, out_exp_owner, out_exp_event,
                           out_exp_queue, out_last});
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !busy)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid is dropped only by an idle cycle or by drain, so it gets one update per step
  task automatic send_cmd(logic [2:0] fn, logic [15:0] o, logic [15:0] e,
                          logic [30:0] dly, logic [15:0] q, logic [30:0] el);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= fn; in_owner <= o; in_event_req <= e;
    in_delay <= dly; in_queue_id <= q; in_elapsed <= el;
    do @(posedge clk); while (!in_ready);
    timers.note_command(fn, o, e, dly, q, el);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (timers.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_max(logic [30:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    timers.max_el = v;
  endtask

  // mostly timers of a few owners so stops and queries hit, with some noise
  task automatic random_cmd();
    logic [2:0] fn;
    logic [15:0] o, e;
    logic [30:0] dly, el;
    int k;
    k = $urandom_range(99);
    fn = (k < 40) ? FN_START : (k < 52) ? FN_STOP_ONE : (k < 60) ? FN_STOP_ALL :
         (k < 70) ? FN_QUERY : (k < 97) ? FN_TICK : 3'($urandom_range(7, 5));
    o = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    e = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    dly = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(200));
    el = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(120));
    send_cmd(fn, o, e, dly, 16'($urandom), el);
  endtask

  initial begin
    busy = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero owner, extremes, full pool, cancel on restart, big tick
    send_cmd(FN_START, 0, 16'hffff, 31'h7fffffff, 16'hffff, 0);
    send_cmd(FN_TICK, 0, 0, 0, 0, 31'h7fffffff);
    send_cmd(FN_START, 16'hffff, 16'hffff, 31'h7fffffff, 16'hffff, 31'h7fffffff);
    send_cmd(FN_START, 16'hffff, 16'hffff, 31'd5, 16'h1234, 0);
    for (int i = 0; i < 17; i++) send_cmd(FN_START, 16'(i + 1), 16'd7, 31'(i % 4), 16'(i), 0);
    send_cmd(FN_QUERY, 16'd3, 0, 0, 0, 0);
    send_cmd(FN_STOP_ONE, 16'd2, 16'd7, 0, 0, 0);
    send_cmd(FN_STOP_ALL, 16'd4, 0, 0, 0, 0);
    send_cmd(FN_TICK, 0, 0, 0, 0, 31'd3);
    send_cmd(3'd7, 16'hffff, 16'hffff, 31'h7fffffff, 16'hffff, 31'h7fffffff);
    write_max(31'd0);
    send_cmd(FN_TICK, 0, 0, 0, 0, 31'h7fffffff);
    write_max(31'h7fffffff);
    send_cmd(FN_TICK, 0, 0, 0, 0, 31'h7fffffff);
    write_max(31'd1);
    send_idle_pct = 10; recv_idle_pct = 78;
    repeat (40) random_cmd();
    write_max(31'd60);
    send_idle_pct = 78; recv_idle_pct = 10;
    repeat (40) random_cmd();
    write_max(31'd1000000);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (40) random_cmd();
    drain();
    if (timers.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

`default_nettype wire
